FILE: src/dlpm_pkg.sv
// Shared types and constants of the DFA longest-prefix match unit.
package dlpm_pkg;

    localparam int ST_W  = 6;   // state field width
    localparam int CH_W  = 8;   // character field width
    localparam int POS_W = 16;  // character position counter width
    localparam int RES_W = 17;  // signed match position width

    localparam logic [POS_W-1:0]        POS_MAX  = {POS_W{1'b1}};
    localparam logic signed [RES_W-1:0] NO_MATCH = {RES_W{1'b1}};

    typedef enum logic [1:0] {
        REQ_TRANS_WR = 2'd0,
        REQ_FLAG_WR  = 2'd1,
        REQ_MATCH    = 2'd2
    } t_req;

    typedef struct packed {
        t_req            op;
        logic [ST_W-1:0] state_index;
        logic [CH_W-1:0] char_code;
        logic [ST_W-1:0] next_state;
        logic            edge_valid;
        logic            accept_flag;
        logic            dead_flag;
        logic            last_char;
        logic            char_ok;
    } t_cmd;

    typedef struct packed {
        logic            valid;
        logic [ST_W-1:0] nxt;
    } t_edge;

    typedef struct packed {
        logic accept;
        logic dead;
    } t_flags;

endpackage

FILE: src/dlpm_req_if.sv
// Request channel: table writes and match characters.
interface dlpm_req_if;
    logic                      valid;
    logic                      ready;
    logic [1:0]                req_type;
    logic [dlpm_pkg::ST_W-1:0] state_index;
    logic [dlpm_pkg::CH_W-1:0] char_code;
    logic [dlpm_pkg::ST_W-1:0] next_state;
    logic                      edge_valid;
    logic                      accept_flag;
    logic                      dead_flag;
    logic                      last_char;

    modport source (
        output valid, req_type, state_index, char_code, next_state,
               edge_valid, accept_flag, dead_flag, last_char,
        input  ready
    );
    modport sink (
        input  valid, req_type, state_index, char_code, next_state,
               edge_valid, accept_flag, dead_flag, last_char,
        output ready
    );
endinterface

FILE: src/dlpm_res_if.sv
// Result channel: match position of a finished string.
interface dlpm_res_if;
    logic                              valid;
    logic                              ready;
    logic signed [dlpm_pkg::RES_W-1:0] match_pos;

    modport source (output valid, match_pos, input ready);
    modport sink (input valid, match_pos, output ready);
endinterface

FILE: src/dlpm_fifo.sv
// Small synchronous FIFO in flip-flops with an occupancy count.
module dlpm_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_push,
    input  logic [WIDTH-1:0]         i_data,
    output logic                     o_full,
    input  logic                     i_pop,
    output logic [WIDTH-1:0]         o_data,
    output logic                     o_empty,
    output logic [$clog2(DEPTH):0]   o_count
);
    localparam int PW = $clog2(DEPTH);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW:0]      r_wr;
    logic [PW:0]      r_rd;

    assign o_count = r_wr - r_rd;
    assign o_full  = (o_count == (PW+1)'(DEPTH));
    assign o_empty = (r_wr == r_rd);
    assign o_data  = r_mem[r_rd[PW-1:0]];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr <= '0;
            r_rd <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + (PW+1)'(1);
            end
            if (i_pop) begin
                r_rd <= r_rd + (PW+1)'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr[PW-1:0]] <= i_data;
        end
    end
endmodule

FILE: src/dlpm_front.sv
// Front end: take requests, decode the type, range-check and drop no-op items.
module dlpm_front #(
    parameter int STATE_COUNT   = 64,
    parameter int ALPHABET_SIZE = 256
) (
    dlpm_req_if.sink        i_req,
    input  logic            i_q_full,
    input  logic            i_clearing,
    output logic            o_push,
    output dlpm_pkg::t_cmd  o_cmd
);
    import dlpm_pkg::*;

    logic w_state_ok;
    logic w_char_ok;
    logic w_keep;

    assign w_state_ok  = (32'(i_req.state_index) < 32'(STATE_COUNT));
    assign w_char_ok   = (32'(i_req.char_code) < 32'(ALPHABET_SIZE));
    assign i_req.ready = !i_q_full && !i_clearing;

    always_comb begin
        o_cmd.op = REQ_MATCH;
        w_keep   = 1'b0;
        unique case (i_req.req_type)
            REQ_TRANS_WR: begin
                o_cmd.op = REQ_TRANS_WR;
                w_keep   = w_state_ok && w_char_ok;
            end
            REQ_FLAG_WR: begin
                o_cmd.op = REQ_FLAG_WR;
                w_keep   = w_state_ok;
            end
            REQ_MATCH: begin
                o_cmd.op = REQ_MATCH;
                w_keep   = 1'b1;
            end
            default: begin
                // unknown request: take it and drop it
                w_keep = 1'b0;
            end
        endcase
        o_cmd.state_index = i_req.state_index;
        o_cmd.char_code   = i_req.char_code;
        o_cmd.next_state  = i_req.next_state;
        o_cmd.edge_valid  = i_req.edge_valid;
        o_cmd.accept_flag = i_req.accept_flag;
        o_cmd.dead_flag   = i_req.dead_flag;
        o_cmd.last_char   = i_req.last_char;
        o_cmd.char_ok     = w_char_ok;
    end

    assign o_push = i_req.valid && i_req.ready && w_keep;
endmodule

FILE: src/dlpm_back.sv
// Back end: transition and flag memories, three-stage DFA walk, clearing pass.
module dlpm_back #(
    parameter int STATE_COUNT   = 64,
    parameter int ALPHABET_SIZE = 256,
    parameter int RES_DEPTH     = 4
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic [dlpm_pkg::ST_W-1:0]         i_start_state,
    input  logic                              i_cmd_valid,
    input  dlpm_pkg::t_cmd                    i_cmd,
    output logic                              o_cmd_pop,
    input  logic [$clog2(RES_DEPTH):0]        i_res_count,
    output logic                              o_res_push,
    output logic signed [dlpm_pkg::RES_W-1:0] o_res_data,
    output logic                              o_clearing
);
    import dlpm_pkg::*;

    localparam int SB    = $clog2(STATE_COUNT);
    localparam int CB    = $clog2(ALPHABET_SIZE);
    localparam int AW    = SB + CB;
    localparam int DEPTH = 2 ** AW;
    localparam int CW    = $clog2(RES_DEPTH) + 1;

    typedef struct packed {
        logic            last;
        logic            lookup_ok;
        logic [ST_W-1:0] state;
    } t_s2;

    typedef struct packed {
        logic last;
        logic has_edge;
        logic state_ok;
    } t_s3;

    t_edge  r_table [DEPTH];
    t_flags r_flags [2 ** SB];
    t_edge  r_tdout;
    t_flags r_fdout;

    logic                     r_clr_active;
    logic [AW-1:0]            r_clr_addr;
    logic                     r_first;
    logic [ST_W-1:0]          r_cur;
    logic                     r_v2;
    t_s2                      r_s2;
    logic                     r_v3;
    t_s3                      r_s3;
    logic                     r_stopped;
    logic [POS_W-1:0]         r_pos;
    logic signed [RES_W-1:0]  r_best;

    logic                     n_stopped;
    logic [POS_W-1:0]         n_pos;
    logic signed [RES_W-1:0]  n_best;

    logic [ST_W-1:0]  w_walk_state;
    logic [31:0]      w_walk_ext;
    logic [31:0]      w_char_ext;
    logic [31:0]      w_widx_ext;
    logic [AW-1:0]    w_rd_addr;
    logic             w_is_match;
    logic             w_lookup_ok;
    logic [CW:0]      w_need;
    logic             w_room;
    logic             w_tw_en;
    logic [AW-1:0]    w_tw_addr;
    t_edge            w_tw_data;
    logic             w_fw_en;
    logic [SB-1:0]    w_fw_addr;
    t_flags           w_fw_data;
    logic             w_has_edge;
    logic [ST_W-1:0]  w_ns;
    logic [31:0]      w_ns_ext;
    t_flags           w_flags;
    logic             w_stopped;
    logic [POS_W-1:0] w_pos;
    logic signed [RES_W-1:0] w_best;

    assign o_clearing = r_clr_active;

    // Stage 1: pick the walk state, forwarding the state just resolved in stage 2.
    assign w_walk_state = r_first ? i_start_state : (r_v2 ? w_ns : r_cur);
    assign w_walk_ext   = 32'(w_walk_state);
    assign w_char_ext   = 32'(i_cmd.char_code);
    assign w_widx_ext   = 32'(i_cmd.state_index);
    assign w_rd_addr    = {w_walk_ext[SB-1:0], w_char_ext[CB-1:0]};
    assign w_is_match   = (i_cmd.op == REQ_MATCH);
    assign w_lookup_ok  = (w_walk_ext < 32'(STATE_COUNT)) && i_cmd.char_ok;

    // Reserve a result slot for every string end still in the pipeline.
    assign w_need = {1'b0, i_res_count}
                  + (CW+1)'(r_v2 && r_s2.last)
                  + (CW+1)'(r_v3 && r_s3.last);
    assign w_room = (w_need < (CW+1)'(RES_DEPTH));

    assign o_cmd_pop = i_cmd_valid && !r_clr_active
                     && (!(w_is_match && i_cmd.last_char) || w_room);

    always_comb begin
        w_tw_en   = r_clr_active || (o_cmd_pop && i_cmd.op == REQ_TRANS_WR);
        w_fw_en   = r_clr_active || (o_cmd_pop && i_cmd.op == REQ_FLAG_WR);
        if (r_clr_active) begin
            w_tw_addr = r_clr_addr;
            w_tw_data = '0;
            w_fw_addr = r_clr_addr[SB-1:0];
            w_fw_data = '0;
        end else begin
            w_tw_addr       = {w_widx_ext[SB-1:0], w_char_ext[CB-1:0]};
            w_tw_data.valid = i_cmd.edge_valid;
            w_tw_data.nxt   = i_cmd.next_state;
            w_fw_addr       = w_widx_ext[SB-1:0];
            w_fw_data.accept = i_cmd.accept_flag;
            w_fw_data.dead   = i_cmd.dead_flag;
        end
    end

    // Stage 2: resolve the edge and look up the flags of the next state.
    assign w_has_edge = r_s2.lookup_ok && r_tdout.valid;
    assign w_ns       = w_has_edge ? r_tdout.nxt : r_s2.state;
    assign w_ns_ext   = 32'(w_ns);

    always_ff @(posedge i_clk) begin
        if (w_tw_en) begin
            r_table[w_tw_addr] <= w_tw_data;
        end
        r_tdout <= r_table[w_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (w_fw_en) begin
            r_flags[w_fw_addr] <= w_fw_data;
        end
        r_fdout <= r_flags[w_ns_ext[SB-1:0]];
    end

    // Stage 3: record the match, stop the walk, count the position.
    assign w_flags = r_s3.state_ok ? r_fdout : '0;

    always_comb begin
        w_best    = r_best;
        w_pos     = r_pos;
        w_stopped = r_stopped;
        if (r_v3 && !r_stopped) begin
            if (r_s3.has_edge && w_flags.accept) begin
                w_best = $signed({1'b0, r_pos});
            end
            if (!r_s3.has_edge || w_flags.dead) begin
                w_stopped = 1'b1;
            end else if (r_pos != POS_MAX) begin
                w_pos = r_pos + POS_W'(1);
            end
        end
        o_res_push = r_v3 && r_s3.last;
        o_res_data = w_best;
        n_best     = w_best;
        n_pos      = w_pos;
        n_stopped  = w_stopped;
        if (r_v3 && r_s3.last) begin
            n_best    = NO_MATCH;
            n_pos     = '0;
            n_stopped = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_active <= 1'b1;
            r_clr_addr   <= '0;
            r_first      <= 1'b1;
            r_v2         <= 1'b0;
            r_v3         <= 1'b0;
            r_stopped    <= 1'b0;
            r_pos        <= '0;
            r_best       <= NO_MATCH;
        end else begin
            if (r_clr_active) begin
                r_clr_addr <= r_clr_addr + AW'(1);
                if (r_clr_addr == {AW{1'b1}}) begin
                    r_clr_active <= 1'b0;
                end
            end
            if (o_cmd_pop && w_is_match) begin
                r_first <= i_cmd.last_char;
            end
            r_v2      <= o_cmd_pop && w_is_match;
            r_v3      <= r_v2;
            r_stopped <= n_stopped;
            r_pos     <= n_pos;
            r_best    <= n_best;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_v2) begin
            r_cur <= w_ns;
        end
        r_s2.last      <= i_cmd.last_char;
        r_s2.lookup_ok <= w_lookup_ok;
        r_s2.state     <= w_walk_state;
        r_s3.last      <= r_s2.last;
        r_s3.has_edge  <= w_has_edge;
        r_s3.state_ok  <= (w_ns_ext < 32'(STATE_COUNT));
    end
endmodule

FILE: src/dfa_longest_prefix_match_unit.sv
// Top level of the DFA longest-prefix match unit.
//
// Request channel i_req (valid/ready) carries three kinds of items: a
// transition write (req_type 0), a state flag write (req_type 1) and a match
// character (req_type 2). Code 3 and writes to an out-of-range state or
// character are taken and dropped. Result channel o_res (valid/ready) gives
// one signed match_pos per string, on the transfer of its last character:
// the index of the last accepting position, or -1.
// The start state register is written through i_cfg_we / i_cfg_wdata.
//
// Throughput: one request per cycle, writes and characters alike, unless
// the request queue is full, a clearing pass runs or a last character waits
// for a result slot. The walk runs as a three-stage loop (transition read,
// flag read, resolve) with the next state forwarded from the transition
// memory read register straight into the next lookup address. Each result
// passes the request and result queues and the stage 2 and 3 registers
// before it can transfer. A 4-entry request queue splits the front end from
// the walk and a 4-entry result queue holds finished results, so a stalled
// receiver only stops the walk once the result queue is reserved full.
// Reset: a clearing pass sweeps both memories; ready stays low meanwhile.
module dfa_longest_prefix_match_unit #(
    parameter int STATE_COUNT   = 64,
    parameter int ALPHABET_SIZE = 256
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [dlpm_pkg::ST_W-1:0] i_cfg_wdata,
    dlpm_req_if.sink                  i_req,
    dlpm_res_if.source                o_res
);
    import dlpm_pkg::*;

    localparam int CMD_DEPTH = 4;
    localparam int RES_DEPTH = 4;
    localparam int CMD_W     = $bits(t_cmd);

    logic [ST_W-1:0] r_start_state;

    logic                          w_push;
    t_cmd                          w_cmd_in;
    logic                          w_q_full;
    logic                          w_q_empty;
    logic [CMD_W-1:0]              w_q_data;
    logic [$clog2(CMD_DEPTH):0]    w_q_count;
    t_cmd                          w_cmd_q;
    logic                          w_pop;
    logic                          w_clearing;
    logic                          w_res_push;
    logic signed [RES_W-1:0]       w_res_data;
    logic [RES_W-1:0]              w_res_q;
    logic                          w_res_empty;
    logic                          w_res_full;
    logic [$clog2(RES_DEPTH):0]    w_res_count;

    // Start state: taken by each string at its first character.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_state <= '0;
        end else if (i_cfg_we) begin
            r_start_state <= i_cfg_wdata;
        end
    end

    dlpm_front #(
        .STATE_COUNT   (STATE_COUNT),
        .ALPHABET_SIZE (ALPHABET_SIZE)
    ) u_front (
        .i_req      (i_req),
        .i_q_full   (w_q_full),
        .i_clearing (w_clearing),
        .o_push     (w_push),
        .o_cmd      (w_cmd_in)
    );

    // Request queue between decode and the walk.
    dlpm_fifo #(
        .WIDTH (CMD_W),
        .DEPTH (CMD_DEPTH)
    ) u_cmd_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_cmd_in),
        .o_full  (w_q_full),
        .i_pop   (w_pop),
        .o_data  (w_q_data),
        .o_empty (w_q_empty),
        .o_count (w_q_count)
    );

    assign w_cmd_q = t_cmd'(w_q_data);

    dlpm_back #(
        .STATE_COUNT   (STATE_COUNT),
        .ALPHABET_SIZE (ALPHABET_SIZE),
        .RES_DEPTH     (RES_DEPTH)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start_state (r_start_state),
        .i_cmd_valid   (!w_q_empty && (w_q_count != '0)),
        .i_cmd         (w_cmd_q),
        .o_cmd_pop     (w_pop),
        .i_res_count   (w_res_count),
        .o_res_push    (w_res_push),
        .o_res_data    (w_res_data),
        .o_clearing    (w_clearing)
    );

    // Result queue: hold finished results while the receiver stalls.
    dlpm_fifo #(
        .WIDTH (RES_W),
        .DEPTH (RES_DEPTH)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_res_push),
        .i_data  (w_res_data),
        .o_full  (w_res_full),
        .i_pop   (o_res.valid && o_res.ready && !w_res_full | o_res.valid && o_res.ready),
        .o_data  (w_res_q),
        .o_empty (w_res_empty),
        .o_count (w_res_count)
    );

    assign o_res.valid     = !w_res_empty;
    assign o_res.match_pos = $signed(w_res_q);
endmodule
